// ===== src/tpz_pkg.sv =====
// Shared types, constants and helper functions for the torus point z-buffer plotter.
// Used by every module of the block but tpz_ram; depends on nothing else.
package tpz_pkg;

    // Screen geometry and the cell memory that follows from it.
    localparam int SCREEN_WIDTH  = 100;
    localparam int SCREEN_HEIGHT = 32;
    localparam int CELLS         = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int CELL_AW       = $clog2(CELLS);
    localparam int X_W           = $clog2(SCREEN_WIDTH);
    localparam int Y_W           = $clog2(SCREEN_HEIGHT);
    localparam int HALF_WIDTH    = SCREEN_WIDTH / 2;
    localparam int HALF_HEIGHT   = SCREEN_HEIGHT / 2;

    // Field widths of the request and the result.
    localparam int COORD_W  = 16;
    localparam int ADDR_W   = 12;
    localparam int CHAR_W   = 7;
    localparam int DEP_W    = 16;
    localparam int SHADE_W  = 4;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 8;

    // Datapath widths of the geometry sequencer and the divider.
    localparam int ACC_W   = 40;
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int NUM_W   = 48;
    localparam int DIV_W   = 52;
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Fixed-point constants.
    localparam int Q14_SHIFT = 14;
    localparam int Q14_BIAS  = 16383;
    localparam logic signed [MUL_B_W-1:0] H_OFFSET = 17'sd32768;
    localparam logic signed [ACC_W-1:0]   SIX_Q28  = 40'sd1610612736;
    localparam logic signed [ACC_W-1:0]   DEP_SAT_D = 40'sd268435456;
    localparam logic signed [DIV_W-1:0]   DEP_NUM  = 52'sd17592186044416;
    localparam logic signed [NUM_W-1:0]   X_SCALE  = 48'sd50;
    localparam logic signed [NUM_W-1:0]   Y_SCALE  = 48'sd25;
    localparam logic signed [NUM_W-1:0]   HALF_W_S = NUM_W'(HALF_WIDTH);
    localparam logic signed [NUM_W-1:0]   HALF_H_S = NUM_W'(HALF_HEIGHT);
    localparam logic signed [NUM_W-1:0]   WIDTH_S  = NUM_W'(SCREEN_WIDTH);
    localparam logic signed [NUM_W-1:0]   HEIGHT_S = NUM_W'(SCREEN_HEIGHT);
    localparam int LUM_SHIFT = 25;

    // Shade codes and characters.
    localparam logic [SHADE_W-1:0] SHADE_MAX   = 4'd11;
    localparam logic [SHADE_W-1:0] SHADE_BLANK = 4'd12;
    localparam logic [CHAR_W-1:0]  CHAR_NL     = 7'd10;
    localparam logic [CHAR_W-1:0]  CHAR_SPACE  = 7'd32;
    localparam logic [CHAR_W-1:0]  CHAR_NONE   = 7'd0;

    // Column of a read address by reciprocal multiplication, exact for any 12-bit address.
    localparam int MOD_S  = ADDR_W + $clog2(SCREEN_WIDTH);
    localparam int MOD_M  = (2 ** MOD_S + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
    localparam int MOD_PW = 2 * ADDR_W + 2;

    // Request kinds.
    localparam logic OP_PLOT = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_COS_A = 2'd0;
    localparam logic [1:0] CFG_SIN_A = 2'd1;
    localparam logic [1:0] CFG_COS_B = 2'd2;
    localparam logic [1:0] CFG_SIN_B = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] sin_theta;
        logic signed [COORD_W-1:0] cos_theta;
        logic signed [COORD_W-1:0] sin_phi;
        logic signed [COORD_W-1:0] cos_phi;
    } t_point;

    typedef struct packed {
        logic signed [COORD_W-1:0] cos_a;
        logic signed [COORD_W-1:0] sin_a;
        logic signed [COORD_W-1:0] cos_b;
        logic signed [COORD_W-1:0] sin_b;
    } t_rot;

    typedef struct packed {
        logic signed [ACC_W-1:0] d;
        logic signed [ACC_W-1:0] xn;
        logic signed [ACC_W-1:0] yn;
        logic signed [ACC_W-1:0] lum;
    } t_geom;

    typedef struct packed {
        logic             in_bounds;
        logic [X_W-1:0]   x;
        logic [Y_W-1:0]   y;
        logic [DEP_W-1:0] depth;
    } t_proj;

    typedef struct packed {
        logic [SHADE_W-1:0] shade;
        logic [DEP_W-1:0]   depth;
    } t_cell;

    // Micro-steps of the shared multiplier, one product per step.
    typedef enum logic [3:0] {
        MS_P, MS_Q, MS_R, MS_CC, MS_PSA, MS_SPCA, MS_PCA, MS_SPSA,
        MS_QCB, MS_TSB, MS_QSB, MS_TCB, MS_RCA, MS_RSA, MS_UCB, MS_CCSB
    } t_mstep;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_GEOM, ST_DIV, ST_PLOT_RD, ST_PLOT_WR,
        ST_READ_RD, ST_READ_WR, ST_DONE
    } t_state;

    // Q14 rescale with truncation toward zero.
    function automatic logic signed [ACC_W-1:0] dq14(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] b;
        b = v;
        if (v < 0) begin
            b = v + PROD_W'(Q14_BIAS);
        end
        return ACC_W'(b >>> Q14_SHIFT);
    endfunction

    // Luminance to shade index, clamped to the character ramp.
    function automatic logic [SHADE_W-1:0] lum_to_shade(input logic signed [ACC_W-1:0] lum);
        logic signed [ACC_W-1:0] n;
        n = lum >>> LUM_SHIFT;
        if (lum < 0) begin
            return '0;
        end else if (n > ACC_W'(SHADE_MAX)) begin
            return SHADE_MAX;
        end
        return SHADE_W'(n);
    endfunction

    // Shade index to ASCII; unused codes read as a space.
    function automatic logic [CHAR_W-1:0] shade_char(input logic [SHADE_W-1:0] s);
        case (s)
            4'd0:    return 7'h2E;
            4'd1:    return 7'h2C;
            4'd2:    return 7'h3A;
            4'd3:    return 7'h3B;
            4'd4:    return 7'h3D;
            4'd5:    return 7'h2B;
            4'd6:    return 7'h2A;
            4'd7:    return 7'h65;
            4'd8:    return 7'h61;
            4'd9:    return 7'h23;
            4'd10:   return 7'h24;
            4'd11:   return 7'h40;
            default: return CHAR_SPACE;
        endcase
    endfunction

endpackage

// ===== src/tpz_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Stand-alone; holds the depth and shade of every screen cell.
module tpz_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 3200
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write first in the array, read the old contents into the output register.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tpz_geom.sv =====
// Rotation and luminance sequencer: one shared signed multiplier, one product per cycle.
// Depends on tpz_pkg for the point, rotation and result types.
module tpz_geom (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  tpz_pkg::t_point i_point,
    input  tpz_pkg::t_rot   i_rot,
    output logic            o_done,
    output tpz_pkg::t_geom  o_res
);

    tpz_pkg::t_point r_pt;
    tpz_pkg::t_mstep r_step;
    tpz_pkg::t_mstep r_pstep;
    logic            r_busy;
    logic            r_pv;
    logic            r_done;
    logic signed [tpz_pkg::PROD_W-1:0]  r_prod;
    logic signed [tpz_pkg::ACC_W-1:0]   r_p, r_q, r_r, r_cc, r_t, r_u;
    logic signed [tpz_pkg::ACC_W-1:0]   r_dd, r_spca, r_spsa, r_xn, r_yn, r_lum;
    logic signed [tpz_pkg::MUL_A_W-1:0] w_op_a;
    logic signed [tpz_pkg::MUL_B_W-1:0] w_op_b;
    logic signed [tpz_pkg::MUL_B_W-1:0] w_h;
    logic signed [tpz_pkg::PROD_W-1:0]  w_prod;
    logic signed [tpz_pkg::ACC_W-1:0]   w_prod_q14;
    logic signed [tpz_pkg::ACC_W-1:0]   w_prod_raw;

    // Tube radius offset: cos_phi plus two in Q14.
    assign w_h = tpz_pkg::MUL_B_W'(r_pt.cos_phi) + tpz_pkg::H_OFFSET;

    // Operand selection for the current step.
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        unique case (r_step)
            tpz_pkg::MS_P: begin
                w_op_a = tpz_pkg::MUL_A_W'(r_pt.sin_theta);
                w_op_b = w_h;
            end
            tpz_pkg::MS_Q: begin
                w_op_a = tpz_pkg::MUL_A_W'(r_pt.cos_theta);
                w_op_b = w_h;
            end
            tpz_pkg::MS_R: begin
                w_op_a = tpz_pkg::MUL_A_W'(r_pt.sin_theta);
                w_op_b = tpz_pkg::MUL_B_W'(r_pt.cos_phi);
            end
            tpz_pkg::MS_CC: begin
                w_op_a = tpz_pkg::MUL_A_W'(r_pt.cos_theta);
                w_op_b = tpz_pkg::MUL_B_W'(r_pt.cos_phi);
            end
            tpz_pkg::MS_PSA: begin
                w_op_a = tpz_pkg::MUL_A_W'(r_p);
                w_op_b = tpz_pkg::MUL_B_W'(i_rot.sin_a);
            end
            tpz_pkg::MS_SPCA: begin
                w_op_a = tpz_pkg::MUL_A_W'(r_pt.sin_phi);
                w_op_b = tpz_pkg::MUL_B_W'(i_rot.cos_a);
            end
            tpz_pkg::MS_PCA: begin
                w_op_a = tpz_pkg::MUL_A_W'(r_p);
                w_op_b = tpz_pkg::MUL_B_W'(i_rot.cos_a);
            end
            tpz_pkg::MS_SPSA: begin
                w_op_a = tpz_pkg::MUL_A_W'(r_pt.sin_phi);
                w_op_b = tpz_pkg::MUL_B_W'(i_rot.sin_a);
            end
            tpz_pkg::MS_QCB: begin
                w_op_a = tpz_pkg::MUL_A_W'(r_q);
                w_op_b = tpz_pkg::MUL_B_W'(i_rot.cos_b);
            end
            tpz_pkg::MS_TSB: begin
                w_op_a = tpz_pkg::MUL_A_W'(r_t);
                w_op_b = tpz_pkg::MUL_B_W'(i_rot.sin_b);
            end
            tpz_pkg::MS_QSB: begin
                w_op_a = tpz_pkg::MUL_A_W'(r_q);
                w_op_b = tpz_pkg::MUL_B_W'(i_rot.sin_b);
            end
            tpz_pkg::MS_TCB: begin
                w_op_a = tpz_pkg::MUL_A_W'(r_t);
                w_op_b = tpz_pkg::MUL_B_W'(i_rot.cos_b);
            end
            tpz_pkg::MS_RCA: begin
                w_op_a = tpz_pkg::MUL_A_W'(r_r);
                w_op_b = tpz_pkg::MUL_B_W'(i_rot.cos_a);
            end
            tpz_pkg::MS_RSA: begin
                w_op_a = tpz_pkg::MUL_A_W'(r_r);
                w_op_b = tpz_pkg::MUL_B_W'(i_rot.sin_a);
            end
            tpz_pkg::MS_UCB: begin
                w_op_a = tpz_pkg::MUL_A_W'(r_u);
                w_op_b = tpz_pkg::MUL_B_W'(i_rot.cos_b);
            end
            tpz_pkg::MS_CCSB: begin
                w_op_a = tpz_pkg::MUL_A_W'(r_cc);
                w_op_b = tpz_pkg::MUL_B_W'(i_rot.sin_b);
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_prod     = w_op_a * w_op_b;
    assign w_prod_q14 = tpz_pkg::dq14(r_prod);
    assign w_prod_raw = tpz_pkg::ACC_W'(r_prod);

    // Step control: sixteen multiplies, then the last accumulate raises done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pv    <= 1'b0;
            r_done  <= 1'b0;
            r_step  <= tpz_pkg::MS_P;
            r_pstep <= tpz_pkg::MS_P;
        end else begin
            r_done <= r_pv && (r_pstep == tpz_pkg::MS_CCSB);
            r_pv   <= r_busy;
            if (r_busy) begin
                r_pstep <= r_step;
                r_step  <= tpz_pkg::t_mstep'(r_step + 4'd1);
                if (r_step == tpz_pkg::MS_CCSB) begin
                    r_busy <= 1'b0;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_step <= tpz_pkg::MS_P;
            end
        end
    end

    // Operand capture, product register and accumulation in the cycle after each product.
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_pt <= i_point;
        end
        r_prod <= w_prod;
        if (r_pv) begin
            case (r_pstep)
                tpz_pkg::MS_P:    r_p    <= w_prod_raw;
                tpz_pkg::MS_Q:    r_q    <= w_prod_raw;
                tpz_pkg::MS_R:    r_r    <= w_prod_raw;
                tpz_pkg::MS_CC:   r_cc   <= w_prod_raw;
                tpz_pkg::MS_PSA:  r_dd   <= w_prod_q14;
                tpz_pkg::MS_SPCA: r_spca <= w_prod_raw;
                tpz_pkg::MS_PCA:  r_t    <= w_prod_q14;
                tpz_pkg::MS_SPSA: begin
                    r_spsa <= w_prod_raw;
                    r_t    <= r_t - w_prod_raw;
                    r_dd   <= r_dd + r_spca + tpz_pkg::SIX_Q28;
                end
                tpz_pkg::MS_QCB:  r_xn  <= w_prod_q14;
                tpz_pkg::MS_TSB:  r_xn  <= r_xn - w_prod_q14;
                tpz_pkg::MS_QSB:  r_yn  <= w_prod_q14;
                tpz_pkg::MS_TCB:  r_yn  <= r_yn + w_prod_q14;
                tpz_pkg::MS_RCA:  r_u   <= r_spsa - w_prod_q14;
                tpz_pkg::MS_RSA:  r_lum <= -w_prod_q14 - r_spca;
                tpz_pkg::MS_UCB:  r_lum <= r_lum + w_prod_q14;
                tpz_pkg::MS_CCSB: r_lum <= r_lum - w_prod_q14;
                default:          r_lum <= r_lum;
            endcase
        end
    end

    assign o_done    = r_done;
    assign o_res.d   = r_dd;
    assign o_res.xn  = r_xn;
    assign o_res.yn  = r_yn;
    assign o_res.lum = r_lum;

endmodule

// ===== src/tpz_div.sv =====
// Projection unit: bounds test and restoring division, one quotient bit per cycle.
// Depends on tpz_pkg; takes the rotated point from tpz_geom.
module tpz_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  tpz_pkg::t_geom i_geom,
    output logic           o_done,
    output tpz_pkg::t_proj o_proj
);

    logic signed [tpz_pkg::NUM_W-1:0] r_nx, r_ny, r_wd, r_hd, r_dn;
    logic signed [tpz_pkg::ACC_W-1:0] r_d;
    logic signed [tpz_pkg::DIV_W-1:0] r_rx, r_ry, r_rz, r_dsh;
    logic [tpz_pkg::X_W-1:0]   r_qx;
    logic [tpz_pkg::Y_W-1:0]   r_qy;
    logic [tpz_pkg::DEP_W-1:0] r_qz;
    logic [tpz_pkg::DIV_CNT_W-1:0] r_cnt;
    logic r_setup, r_busy, r_done, r_inb, r_sat;
    logic signed [tpz_pkg::NUM_W-1:0] w_d, w_xn, w_yn;
    logic w_bx, w_by, w_bz;

    assign w_d  = tpz_pkg::NUM_W'(i_geom.d);
    assign w_xn = tpz_pkg::NUM_W'(i_geom.xn);
    assign w_yn = tpz_pkg::NUM_W'(i_geom.yn);

    // One trial subtraction per remainder.
    assign w_bx = (r_rx >= r_dsh);
    assign w_by = (r_ry >= r_dsh);
    assign w_bz = (r_rz >= r_dsh);

    // Control: setup cycle, then the division steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup <= 1'b0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_setup <= 1'b1;
            end else if (r_setup) begin
                r_setup <= 1'b0;
                r_busy  <= 1'b1;
                r_cnt   <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == tpz_pkg::DIV_CNT_W'(tpz_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: numerators, bounds, then shift-and-subtract.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d  <= i_geom.d;
            r_dn <= w_d;
            r_nx <= w_d * tpz_pkg::HALF_W_S + w_xn * tpz_pkg::X_SCALE;
            r_ny <= w_d * tpz_pkg::HALF_H_S + w_yn * tpz_pkg::Y_SCALE;
            r_wd <= w_d * tpz_pkg::WIDTH_S;
            r_hd <= w_d * tpz_pkg::HEIGHT_S;
        end else if (r_setup) begin
            // The screen bounds hold exactly when d > 0 and d <= N < size * d on both axes.
            r_inb <= (r_d > 0) && (r_nx >= r_dn) && (r_nx < r_wd)
                     && (r_ny >= r_dn) && (r_ny < r_hd);
            r_sat <= (r_d <= tpz_pkg::DEP_SAT_D);
            r_rx  <= tpz_pkg::DIV_W'(r_nx);
            r_ry  <= tpz_pkg::DIV_W'(r_ny);
            r_rz  <= tpz_pkg::DEP_NUM;
            r_dsh <= tpz_pkg::DIV_W'(r_d) <<< (tpz_pkg::DIV_STEPS - 1);
        end else if (r_busy) begin
            if (w_bx) begin
                r_rx <= r_rx - r_dsh;
            end
            if (w_by) begin
                r_ry <= r_ry - r_dsh;
            end
            if (w_bz) begin
                r_rz <= r_rz - r_dsh;
            end
            r_qx  <= {r_qx[tpz_pkg::X_W-2:0], w_bx};
            r_qy  <= {r_qy[tpz_pkg::Y_W-2:0], w_by};
            r_qz  <= {r_qz[tpz_pkg::DEP_W-2:0], w_bz};
            r_dsh <= r_dsh >>> 1;
        end
    end

    assign o_done           = r_done;
    assign o_proj.in_bounds = r_inb;
    assign o_proj.x         = r_qx;
    assign o_proj.y         = r_qy;
    assign o_proj.depth     = r_sat ? {tpz_pkg::DEP_W{1'b1}} : r_qz;

endmodule

// ===== src/torus_point_zbuffer_plotter_top.sv =====
// Top level of the torus point z-buffer plotter: control, cell memory and stream ports.
// Depends on tpz_pkg, tpz_ram, tpz_geom and tpz_div.
//
// Usage:
// A request arrives on the s_axis channel; tuser selects a plot (0) or a read (1).
// Each request gives exactly one result on the m_axis channel.
// A plot rotates the point on the shared multiplier (16 products), then projects it
// in the divider (setup, then 16 quotient steps, then done), then does a
// read-modify-write of its cell in the cell memory. A point that misses the screen
// skips the cell memory. s_axis_tready rises in the same cycle as the result is
// presented.
// A read runs memory read, shade lookup with clear and output load, in that order;
// an address off the screen skips the lookup and the clear.
// One request is in work at a time; s_axis_tready is high only between requests.
// A finished result waits in the output register while the next request is taken;
// when the receiver stalls, the block holds its next result until the register frees.
// After reset a clearing pass writes every cell blank, one cell a cycle, across all
// 3200 cells; no request is taken meanwhile, configuration is.
// Configuration writes are taken at any edge with i_cfg_we high, outside reset.
module torus_point_zbuffer_plotter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sin_theta[15:0], cos_theta[31:16], sin_phi[47:32], cos_phi[63:48],
    // cell_address[75:64], zero[79:76]
    input  logic [tpz_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // op[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // char_code[6:0], plotted[7]
    output logic [tpz_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    tpz_pkg::t_state r_state, n_state;
    tpz_pkg::t_rot   r_rot;
    tpz_pkg::t_point w_point;
    tpz_pkg::t_geom  w_geom;
    tpz_pkg::t_proj  w_proj;
    tpz_pkg::t_cell  w_rd_cell, w_ram_wcell;
    logic [tpz_pkg::CELL_AW-1:0] r_clr, r_cell, w_ram_addr, w_cell;
    logic [tpz_pkg::ADDR_W-1:0]  r_addr, r_quo, w_col;
    logic [tpz_pkg::MOD_PW-1:0]  w_mprod;
    logic [tpz_pkg::SHADE_W-1:0] r_shade;
    logic [tpz_pkg::CHAR_W-1:0]  r_res_char, w_char;
    logic r_res_plot, r_m_valid;
    logic [tpz_pkg::OUT_DATA_W-1:0] r_m_data;
    logic w_accept, w_geom_start, w_geom_done, w_div_done, w_out_free;
    logic w_ram_we, w_win, w_addr_ok;

    assign w_accept     = s_axis_tvalid && s_axis_tready;
    assign w_geom_start = w_accept && (s_axis_tuser == tpz_pkg::OP_PLOT);
    assign w_out_free   = !r_m_valid || m_axis_tready;

    // Request unpacking.
    assign w_point.sin_theta = s_axis_tdata[15:0];
    assign w_point.cos_theta = s_axis_tdata[31:16];
    assign w_point.sin_phi   = s_axis_tdata[47:32];
    assign w_point.cos_phi   = s_axis_tdata[63:48];

    tpz_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_geom_start),
        .i_point (w_point),
        .i_rot   (r_rot),
        .o_done  (w_geom_done),
        .o_res   (w_geom)
    );

    tpz_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_geom_done),
        .i_geom  (w_geom),
        .o_done  (w_div_done),
        .o_proj  (w_proj)
    );

    logic [$bits(tpz_pkg::t_cell)-1:0] w_ram_rdata;

    tpz_ram #(
        .WIDTH ($bits(tpz_pkg::t_cell)),
        .DEPTH (tpz_pkg::CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wcell),
        .o_rdata (w_ram_rdata)
    );

    assign w_rd_cell = w_ram_rdata;

    // Cell index of a projected point, depth test and read-side column.
    assign w_cell = tpz_pkg::CELL_AW'(w_proj.x)
                    + tpz_pkg::CELL_AW'(tpz_pkg::CELL_AW'(w_proj.y)
                                        * tpz_pkg::CELL_AW'(tpz_pkg::SCREEN_WIDTH));
    assign w_win     = w_proj.depth > w_rd_cell.depth;
    assign w_addr_ok = 16'(r_addr) < 16'(tpz_pkg::CELLS);
    assign w_mprod   = tpz_pkg::MOD_PW'(r_addr) * tpz_pkg::MOD_PW'(tpz_pkg::MOD_M);
    assign w_col     = r_addr - tpz_pkg::ADDR_W'(r_quo
                                                 * tpz_pkg::ADDR_W'(tpz_pkg::SCREEN_WIDTH));
    assign w_char    = (w_col == '0) ? tpz_pkg::CHAR_NL : tpz_pkg::shade_char(w_rd_cell.shade);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tpz_pkg::ST_CLEAR: begin
                if (r_clr == tpz_pkg::CELL_AW'(tpz_pkg::CELLS - 1)) begin
                    n_state = tpz_pkg::ST_IDLE;
                end
            end
            tpz_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = (s_axis_tuser == tpz_pkg::OP_READ) ? tpz_pkg::ST_READ_RD
                                                                 : tpz_pkg::ST_GEOM;
                end
            end
            tpz_pkg::ST_GEOM: begin
                if (w_geom_done) begin
                    n_state = tpz_pkg::ST_DIV;
                end
            end
            tpz_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = w_proj.in_bounds ? tpz_pkg::ST_PLOT_RD : tpz_pkg::ST_DONE;
                end
            end
            tpz_pkg::ST_PLOT_RD: n_state = tpz_pkg::ST_PLOT_WR;
            tpz_pkg::ST_PLOT_WR: n_state = tpz_pkg::ST_DONE;
            tpz_pkg::ST_READ_RD: n_state = w_addr_ok ? tpz_pkg::ST_READ_WR : tpz_pkg::ST_DONE;
            tpz_pkg::ST_READ_WR: n_state = tpz_pkg::ST_DONE;
            tpz_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = tpz_pkg::ST_IDLE;
                end
            end
            default: n_state = tpz_pkg::ST_CLEAR;
        endcase
    end

    // Memory port and handshake outputs by state.
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_addr  = r_cell;
        w_ram_wcell = '{shade: tpz_pkg::SHADE_BLANK, depth: '0};
        unique case (r_state)
            tpz_pkg::ST_CLEAR: begin
                w_ram_we   = 1'b1;
                w_ram_addr = r_clr;
            end
            tpz_pkg::ST_PLOT_RD: w_ram_addr = w_cell;
            tpz_pkg::ST_PLOT_WR: begin
                w_ram_we    = w_win;
                w_ram_addr  = r_cell;
                w_ram_wcell = '{shade: r_shade, depth: w_proj.depth};
            end
            tpz_pkg::ST_READ_RD: w_ram_addr = tpz_pkg::CELL_AW'(r_addr);
            tpz_pkg::ST_READ_WR: begin
                w_ram_we   = 1'b1;
                w_ram_addr = tpz_pkg::CELL_AW'(r_addr);
            end
            default: w_ram_we = 1'b0;
        endcase
    end

    assign s_axis_tready = (r_state == tpz_pkg::ST_IDLE);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tpz_pkg::ST_CLEAR;
            r_clr     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tpz_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == tpz_pkg::ST_DONE && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot.cos_a <= 16'sd16384;
            r_rot.sin_a <= 16'sd0;
            r_rot.cos_b <= 16'sd16384;
            r_rot.sin_b <= 16'sd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tpz_pkg::CFG_COS_A: r_rot.cos_a <= i_cfg_data;
                tpz_pkg::CFG_SIN_A: r_rot.sin_a <= i_cfg_data;
                tpz_pkg::CFG_COS_B: r_rot.cos_b <= i_cfg_data;
                tpz_pkg::CFG_SIN_B: r_rot.sin_b <= i_cfg_data;
                default:            r_rot.sin_b <= r_rot.sin_b;
            endcase
        end
    end

    // Payload registers of the request in work and of the result.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr     <= s_axis_tdata[75:64];
            r_res_char <= tpz_pkg::CHAR_NONE;
            r_res_plot <= 1'b0;
        end
        if (r_state == tpz_pkg::ST_PLOT_RD) begin
            r_cell  <= w_cell;
            r_shade <= tpz_pkg::lum_to_shade(w_geom.lum);
        end
        if (r_state == tpz_pkg::ST_PLOT_WR) begin
            r_res_plot <= w_win;
        end
        if (r_state == tpz_pkg::ST_READ_RD) begin
            r_quo <= tpz_pkg::ADDR_W'(w_mprod >> tpz_pkg::MOD_S);
        end
        if (r_state == tpz_pkg::ST_READ_WR) begin
            r_res_char <= w_char;
        end
        if (r_state == tpz_pkg::ST_DONE && w_out_free) begin
            r_m_data <= {r_res_plot, r_res_char};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

`ifndef SYNTHESIS
    // The geometry result arrives only while control waits for it.
    a_geom_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_geom_done |-> (r_state == tpz_pkg::ST_GEOM))
        else $error("geometry done outside its wait state");

    // Read-issue cycles never write the cell memory.
    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tpz_pkg::ST_PLOT_RD || r_state == tpz_pkg::ST_READ_RD) |-> !w_ram_we)
        else $error("cell memory written during a read cycle");

    // A finished result lands in the output register.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tpz_pkg::ST_DONE && w_out_free) |=> m_axis_tvalid)
        else $error("result not presented");

    // Leaving the clearing pass only after the last cell.
    a_clear_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == tpz_pkg::ST_CLEAR && r_state == tpz_pkg::ST_IDLE)
        |-> ($past(r_clr) == tpz_pkg::CELL_AW'(tpz_pkg::CELLS - 1)))
        else $error("clearing pass ended early");
`endif

endmodule

// ===== test/tb_torus_point_zbuffer_plotter_top.sv =====
// Self-checking testbench for the torus point z-buffer plotter top level.
// Depends on tpz_pkg and torus_point_zbuffer_plotter_top; a local predictor
// keeps its own depth and shade screens and checks every result in order.
`timescale 1ns / 1ps

module tb_torus_point_zbuffer_plotter_top;

    localparam int RESET_CYCLES = 12;
    localparam int MAX_SHOWN = 10;

    typedef struct {
        logic                               op;
        logic signed [tpz_pkg::COORD_W-1:0] sin_theta;
        logic signed [tpz_pkg::COORD_W-1:0] cos_theta;
        logic signed [tpz_pkg::COORD_W-1:0] sin_phi;
        logic signed [tpz_pkg::COORD_W-1:0] cos_phi;
        logic [tpz_pkg::ADDR_W-1:0]         cell_address;
    } t_request;

    typedef struct {
        logic [tpz_pkg::CHAR_W-1:0] char_code;
        logic                       plotted;
    } t_pixel_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [1:0]                     i_cfg_idx;
    logic [15:0]                    i_cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [tpz_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                           s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [tpz_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    torus_point_zbuffer_plotter_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Predictor state: rotation copy and both screens.
    logic signed [15:0] rot_cos_a, rot_sin_a, rot_cos_b, rot_sin_b;
    logic [tpz_pkg::DEP_W-1:0]   depth_screen [tpz_pkg::CELLS];
    logic [tpz_pkg::SHADE_W-1:0] shade_screen [tpz_pkg::CELLS];
    string              shade_ramp = ".,:;=+*ea#$@";

    t_request      request_q [$];
    t_pixel_result pixel_q [$];
    int            mismatches = 0;

    function automatic longint q14_div(input longint v);
        return v / 16384;
    endfunction

    // Works out the result of one request and updates the predicted screens.
    function automatic t_pixel_result render_request(input t_request req);
        t_pixel_result res;
        longint st, ct, sp, cp, ca, sa, cb, sb;
        longint h, p, q, d, t, xn, yn, x, y, dep, r, u, lum, n;
        int cell_idx;
        res.char_code = tpz_pkg::CHAR_NONE;
        res.plotted = 1'b0;
        if (req.op == tpz_pkg::OP_READ) begin
            cell_idx = req.cell_address;
            if (cell_idx < tpz_pkg::CELLS) begin
                if (cell_idx % tpz_pkg::SCREEN_WIDTH == 0) res.char_code = tpz_pkg::CHAR_NL;
                else if (shade_screen[cell_idx] < 12)
                    res.char_code = tpz_pkg::CHAR_W'(shade_ramp[shade_screen[cell_idx]]);
                else res.char_code = tpz_pkg::CHAR_SPACE;
                depth_screen[cell_idx] = '0;
                shade_screen[cell_idx] = tpz_pkg::SHADE_BLANK;
            end
            return res;
        end
        st = req.sin_theta; ct = req.cos_theta; sp = req.sin_phi; cp = req.cos_phi;
        ca = rot_cos_a; sa = rot_sin_a; cb = rot_cos_b; sb = rot_sin_b;
        h = cp + 32768;
        p = st * h;
        q = ct * h;
        d = q14_div(p * sa) + sp * ca + (64'sd6 <<< 28);
        t = q14_div(p * ca) - sp * sa;
        xn = q14_div(q * cb) - q14_div(t * sb);
        yn = q14_div(q * sb) + q14_div(t * cb);
        if (d <= 0) return res;
        x = (longint'(tpz_pkg::HALF_WIDTH) * d + 50 * xn) / d;
        y = (longint'(tpz_pkg::HALF_HEIGHT) * d + 25 * yn) / d;
        dep = (64'sd1 <<< 44) / d;
        if (dep > 65535) dep = 65535;
        r = st * cp;
        u = sp * sa - q14_div(r * ca);
        lum = q14_div(u * cb) - q14_div(r * sa) - sp * ca - q14_div(ct * cp * sb);
        n = (8 * lum) / (64'sd1 <<< 28);
        if (n < 0) n = 0;
        if (n > 11) n = 11;
        if (y > 0 && y < tpz_pkg::SCREEN_HEIGHT && x > 0 && x < tpz_pkg::SCREEN_WIDTH) begin
            cell_idx = int'(x + y * tpz_pkg::SCREEN_WIDTH);
            if (dep > longint'(depth_screen[cell_idx])) begin
                depth_screen[cell_idx] = tpz_pkg::DEP_W'(dep);
                shade_screen[cell_idx] = tpz_pkg::SHADE_W'(n);
                res.plotted = 1'b1;
            end
        end
        return res;
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Limit on the whole run.
    initial begin
        #8ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Request driver: bursts of random length, random gaps between them.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_request nxt;
        logic     next_valid;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
        end else begin
            next_valid = 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                nxt.op = s_axis_tuser;
                {nxt.cell_address, nxt.cos_phi, nxt.sin_phi, nxt.cos_theta, nxt.sin_theta}
                    = s_axis_tdata[75:0];
                pixel_q.push_back(render_request(nxt));
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                next_valid = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (request_q.size() > 0) begin
                nxt = request_q.pop_front();
                next_valid = 1'b1;
                s_axis_tuser <= nxt.op;
                s_axis_tdata <= {4'b0, nxt.cell_address, nxt.cos_phi, nxt.sin_phi,
                                 nxt.cos_theta, nxt.sin_theta};
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // Result receiver: own stall pattern plus one long hold-off.
    int ready_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    int results_seen = 0;
    logic hold_done = 1'b0;
    always @(posedge i_clk) begin
        logic rdy;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) results_seen++;
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (ready_mode)
                0: rdy = 1'b1;
                1: rdy = ($urandom_range(0, 1) == 0);
                2: rdy = ($urandom_range(0, 3) == 0);
                default: rdy = ($urandom_range(0, 7) != 0);
            endcase
            if (!hold_done && results_seen >= 300) begin
                hold_done = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end
            m_axis_tready <= rdy;
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_pixel_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pixel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("Unexpected result: tdata=%h", m_axis_tdata);
            end else begin
                want = pixel_q.pop_front();
                if (m_axis_tdata[6:0] !== want.char_code || m_axis_tdata[7] !== want.plotted)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("Mismatch: char_code exp %0d got %0d, plotted exp %0d got %0d",
                                 want.char_code, m_axis_tdata[6:0], want.plotted,
                                 m_axis_tdata[7]);
                end
            end
        end
    end

    function automatic logic signed [15:0] to_q14(input real v);
        return 16'($rtoi(v * 16384.0 + ((v >= 0.0) ? 0.5 : -0.5)));
    endfunction

    function automatic t_request make_plot(input logic signed [15:0] st, ct, sp, cp);
        t_request req;
        req.op = tpz_pkg::OP_PLOT;
        req.sin_theta = st; req.cos_theta = ct; req.sin_phi = sp; req.cos_phi = cp;
        req.cell_address = 12'($urandom);
        return req;
    endfunction

    function automatic t_request make_read(input logic [tpz_pkg::ADDR_W-1:0] addr);
        t_request req;
        req.op = tpz_pkg::OP_READ;
        req.sin_theta = 16'($urandom); req.cos_theta = 16'($urandom);
        req.sin_phi = 16'($urandom); req.cos_phi = 16'($urandom);
        req.cell_address = addr;
        return req;
    endfunction

    // A random request: mostly surface points on the torus, some raw noise, some reads.
    function automatic t_request random_request();
        real th, ph;
        int  pick;
        pick = $urandom_range(0, 99);
        th = $urandom_range(0, 62831) / 10000.0;
        ph = $urandom_range(0, 62831) / 10000.0;
        if (pick < 65)
            return make_plot(to_q14($sin(th)), to_q14($cos(th)), to_q14($sin(ph)),
                             to_q14($cos(ph)));
        if (pick < 75)
            return make_plot(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        if (pick < 95)
            return make_read(12'($urandom_range(0, tpz_pkg::CELLS - 1)));
        return make_read(12'($urandom_range(tpz_pkg::CELLS, 4095)));
    endfunction

    task automatic wait_drained();
        while (request_q.size() > 0 || s_axis_tvalid || pixel_q.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Writes all four rotation registers while the block is idle.
    task automatic set_rotation(input logic signed [15:0] ca, sa, cb, sb);
        logic signed [15:0] vals [4];
        vals = '{ca, sa, cb, sb};
        for (int i = 0; i < 4; i++) begin
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 2'(i);
            i_cfg_data <= vals[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rot_cos_a = ca; rot_sin_a = sa; rot_cos_b = cb; rot_sin_b = sb;
    endtask

    // Stimulus phases.
    initial begin
        real a, b;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = tpz_pkg::CFG_COS_A;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = tpz_pkg::OP_PLOT;
        m_axis_tready = 1'b0;
        rot_cos_a = 16384; rot_sin_a = 0; rot_cos_b = 16384; rot_sin_b = 0;
        for (int i = 0; i < tpz_pkg::CELLS; i++) begin
            depth_screen[i] = '0;
            shade_screen[i] = tpz_pkg::SHADE_BLANK;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset rotation.
        request_q.push_back(make_plot(16'sd0, 16'sd16384, 16'sd0, 16'sd16384));
        request_q.push_back(make_plot(16'sd0, 16'sd16384, 16'sd0, 16'sd16384));
        request_q.push_back(make_plot(16'sd16384, 16'sd0, 16'sd16384, 16'sd0));
        request_q.push_back(make_plot(-16'sd16384, 16'sd0, -16'sd16384, 16'sd0));
        request_q.push_back(make_plot(16'sd0, -16'sd16384, 16'sd0, -16'sd16384));
        request_q.push_back(make_plot(16'sd11585, 16'sd11585, -16'sd11585, 16'sd11585));
        request_q.push_back(make_plot(-16'sd11585, 16'sd11585, 16'sd11585, -16'sd11585));
        request_q.push_back(make_plot(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
        request_q.push_back(make_plot(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
        request_q.push_back(make_plot(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF));
        request_q.push_back(make_read(12'd0));
        request_q.push_back(make_read(12'd1600));
        request_q.push_back(make_read(12'd1650));
        request_q.push_back(make_read(12'd1));
        request_q.push_back(make_read(12'd99));
        request_q.push_back(make_read(12'd3199));
        request_q.push_back(make_read(12'd3200));
        request_q.push_back(make_read(12'd4095));
        for (int i = 0; i < 4; i++) request_q.push_back(random_request());
        wait_drained();

        // Out-of-range rotation that drives the depth to zero or below.
        set_rotation(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        request_q.push_back(make_plot(16'sh8000, 16'sd0, 16'sh7FFF, 16'sh7FFF));
        request_q.push_back(make_plot(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000));
        wait_drained();

        // Random phases over several rotations, extremes first.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_rotation(16'sd16384, 16'sd0, 16'sd16384, 16'sd0);
                1: set_rotation(-16'sd16384, 16'sd16384, -16'sd16384, -16'sd16384);
                2: set_rotation(16'sd0, -16'sd16384, 16'sd0, 16'sd16384);
                3: set_rotation(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                default: begin
                    a = $urandom_range(0, 62831) / 10000.0;
                    b = $urandom_range(0, 62831) / 10000.0;
                    set_rotation(to_q14($cos(a)), to_q14($sin(a)), to_q14($cos(b)),
                                 to_q14($sin(b)));
                end
            endcase
            for (int i = 0; i < 125; i++) request_q.push_back(random_request());
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
